FILE: sv/tbtc_pkg.sv
// Shared types, codes and constants of the time-bucketed traffic counter.
`timescale 1ns / 1ps

package tbtc_pkg;

   // Field widths fixed by the stream format
   localparam int TS_W    = 32;
   localparam int CNT_W   = 16;
   localparam int POS_W   = 6;
   localparam int MODE_W  = 2;
   localparam int CSR_A_W = 2;

   // Defaults for the top-level parameters
   localparam int BUCKETS_DEF          = 64;
   localparam int BUCKET_LENGTH_MS_DEF = 60000;

   // Register reset values and saturation limit
   localparam logic [CNT_W-1:0] FINE_CLAMP_RST = 16'd9999;
   localparam logic [CNT_W-1:0] PAIR_CLAMP_RST = 16'd999;
   localparam logic [CNT_W-1:0] COUNT_MAX      = 16'hFFFF;

   // Register indexes of the configuration channel
   localparam logic [CSR_A_W-1:0] CSR_FINE_CLAMP = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_PAIR_CLAMP = 2'd1;

   // Item kinds
   typedef enum logic [MODE_W-1:0] {
      MODE_REC_RX    = 2'd0,
      MODE_REC_TX    = 2'd1,
      MODE_READ_FINE = 2'd2,
      MODE_READ_PAIR = 2'd3
   } mode_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_ROT,
      ST_STEP,
      ST_OP,
      ST_REC_WR,
      ST_RD_A,
      ST_RD_B,
      ST_LOAD
   } state_type;

   // One ring entry
   typedef struct packed {
      logic [CNT_W-1:0] tx;
      logic [CNT_W-1:0] rx;
   } entry_type;

   // Ring operation strobes from the sequencer
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_one;
      logic clr_all;
   } ring_ctl_type;

endpackage

FILE: sv/tbtc_div.sv
// Division by a constant through a two-pass reciprocal multiply on one shared multiplier.
`timescale 1ns / 1ps

module tbtc_div #(
   parameter int DIVISOR = tbtc_pkg::BUCKET_LENGTH_MS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [tbtc_pkg::TS_W-1:0] dividend,
   output logic                      done,
   output logic [tbtc_pkg::TS_W-1:0] quotient
);

   // floor(x / d) == (x * (floor(2^(32+l) / d) + 1)) >> (32 + l), l = ceil(log2 d)
   localparam int              SH       = tbtc_pkg::TS_W + $clog2(DIVISOR);
   localparam logic [63:0]     RECIP    = ((64'd1 << SH) / 64'(DIVISOR)) + 64'd1;
   localparam int              HW       = 17;
   localparam int              PROD_W   = tbtc_pkg::TS_W + HW;
   localparam int              ACC_W    = tbtc_pkg::TS_W + 2 * HW;
   localparam logic [HW-1:0]   RECIP_LO = RECIP[HW-1:0];
   localparam logic [HW-1:0]   RECIP_HI = RECIP[2*HW-1:HW];

   logic                      busy_ff, busy_in;
   logic                      phase_ff, phase_in;
   logic                      done_ff, done_in;
   logic [tbtc_pkg::TS_W-1:0] x_ff, x_in;
   logic [ACC_W-1:0]          acc_ff, acc_in;
   logic [HW-1:0]             mul_sel;
   logic [PROD_W-1:0]         prod;

   // Multiply by the low half of the reciprocal, then add in the high half
   always_comb begin
      mul_sel  = phase_ff ? RECIP_HI : RECIP_LO;
      prod     = x_ff * mul_sel;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      done_in  = 1'b0;
      x_in     = x_ff;
      acc_in   = acc_ff;
      if (!busy_ff && start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         x_in     = dividend;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            acc_in   = {{HW{1'b0}}, prod};
            phase_in = 1'b1;
         end else begin
            acc_in  = acc_ff + {prod, {HW{1'b0}}};
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   // Advance the datapath
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      acc_ff <= acc_in;
   end

   assign done     = done_ff;
   assign quotient = tbtc_pkg::TS_W'(acc_ff >> SH);

endmodule

FILE: sv/tbtc_ring.sv
// Bucket ring: count memory with per-entry valid bits and registered read.
`timescale 1ns / 1ps

module tbtc_ring #(
   parameter int DEPTH = tbtc_pkg::BUCKETS_DEF,
   parameter int AW    = $clog2(tbtc_pkg::BUCKETS_DEF)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tbtc_pkg::ring_ctl_type ctl,
   input  logic [AW-1:0]          rd_addr,
   input  logic [AW-1:0]          wr_addr,
   input  tbtc_pkg::entry_type    wr_data,
   output tbtc_pkg::entry_type    rd_data
);

   tbtc_pkg::entry_type mem [DEPTH];
   tbtc_pkg::entry_type rd_data_ff;
   logic                rd_valid_ff;
   logic [DEPTH-1:0]    valid_ff;

   // Write and read the count memory
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Track which entries hold data; a cleared entry reads as zero
   always_ff @(posedge clock) begin
      if (reset || ctl.clr_all) begin
         valid_ff <= '0;
      end else if (ctl.clr_one) begin
         valid_ff[wr_addr] <= 1'b0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

FILE: sv/time_bucketed_traffic_counter.sv
// Sequence: a taken beat gets its bucket number from the divider (two-pass reciprocal multiply),
// then the ring rotates, clearing one slot per bucket stepped over (or the whole ring on a gap
// of a ring or more), and the item is dispatched: a record reads and writes back its bucket, a
// readout loads each result (single or pairs) into the result register in turn. The block takes
// no new item until the last is done; beats also wait while a readout waits on a stalled result
// register. Reset: synchronous; ring reads all zero.
`timescale 1ns / 1ps

module time_bucketed_traffic_counter #(
   parameter int BUCKETS          = tbtc_pkg::BUCKETS_DEF,
   parameter int BUCKET_LENGTH_MS = tbtc_pkg::BUCKET_LENGTH_MS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // Item channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [tbtc_pkg::TS_W-1:0]        req_tdata,  // [31:0] now_ms
   input  logic [tbtc_pkg::MODE_W-1:0]      req_tuser,  // [1:0] mode
   // Result channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [39:0]                      rsp_tdata,  // [5:0] position, [21:6] rx_count,
                                                        // [37:22] tx_count, [39:38] zero
   output logic                             rsp_tlast,  // last
   // Configuration channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tbtc_pkg::CSR_A_W-1:0]     csr_index,
   input  logic [tbtc_pkg::CNT_W-1:0]       csr_data
);

   localparam int IDX_W = $clog2(BUCKETS);
   localparam logic [IDX_W-1:0] LAST_FINE = IDX_W'(BUCKETS - 1);
   localparam logic [IDX_W-1:0] LAST_PAIR = IDX_W'(BUCKETS / 2 - 1);

   localparam int CW = tbtc_pkg::CNT_W;

   tbtc_pkg::state_type    state_ff, state_in;
   tbtc_pkg::mode_type     mode_ff, mode_in;
   logic                   started_ff, started_in;
   logic [IDX_W-1:0]       write_slot_ff, write_slot_in;
   logic [tbtc_pkg::TS_W-1:0] latched_ff, latched_in;
   logic [IDX_W-1:0]       step_cnt_ff, step_cnt_in;
   logic [IDX_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   tbtc_pkg::entry_type    pair_a_ff, pair_a_in;
   logic [CW-1:0]          fine_clamp_ff, fine_clamp_in;
   logic [CW-1:0]          pair_clamp_ff, pair_clamp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [IDX_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [CW-1:0]          rsp_rx_ff, rsp_rx_in;
   logic [CW-1:0]          rsp_tx_ff, rsp_tx_in;

   logic                      req_beat;
   logic                      div_done;
   logic [tbtc_pkg::TS_W-1:0] bucket;
   logic [tbtc_pkg::TS_W-1:0] gap;
   logic                      out_free;
   logic                      last_hit;
   logic [CW:0]               rx_sum;
   logic [CW:0]               tx_sum;
   logic [IDX_W-1:0]          slot_step;

   tbtc_pkg::ring_ctl_type ring_ctl;
   logic [IDX_W-1:0]       ring_rd_addr;
   logic [IDX_W-1:0]       ring_wr_addr;
   tbtc_pkg::entry_type    ring_wr_data;
   tbtc_pkg::entry_type    ring_rd_data;

   // Step a slot index round the ring
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
      next_slot = (s == LAST_FINE) ? '0 : s + 1'b1;
   endfunction

   assign req_beat   = req_tvalid && req_tready;
   assign req_tready = (state_ff == tbtc_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign gap        = bucket - latched_ff;
   assign slot_step  = next_slot(write_slot_ff);

   // Bucket number of the timestamp
   tbtc_div #(
      .DIVISOR (BUCKET_LENGTH_MS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_beat),
      .dividend (req_tdata),
      .done     (div_done),
      .quotient (bucket)
   );

   // Count storage
   tbtc_ring #(
      .DEPTH (BUCKETS),
      .AW    (IDX_W)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ring_ctl),
      .rd_addr (ring_rd_addr),
      .wr_addr (ring_wr_addr),
      .wr_data (ring_wr_data),
      .rd_data (ring_rd_data)
   );

   // Sequencer: rotate, then record or read out
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      started_in    = started_ff;
      write_slot_in = write_slot_ff;
      latched_in    = latched_ff;
      step_cnt_in   = step_cnt_ff;
      rd_ptr_in     = rd_ptr_ff;
      pos_in        = pos_ff;
      pair_a_in     = pair_a_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_last_in   = rsp_last_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_rx_in     = rsp_rx_ff;
      rsp_tx_in     = rsp_tx_ff;
      ring_ctl      = '0;
      ring_rd_addr  = rd_ptr_ff;
      ring_wr_addr  = write_slot_ff;
      ring_wr_data  = ring_rd_data;
      last_hit      = (mode_ff == tbtc_pkg::MODE_READ_PAIR) ? (pos_ff == LAST_PAIR)
                                                            : (pos_ff == LAST_FINE);
      rx_sum        = {1'b0, pair_a_ff.rx} + {1'b0, ring_rd_data.rx};
      tx_sum        = {1'b0, pair_a_ff.tx} + {1'b0, ring_rd_data.tx};

      unique case (state_ff)
         tbtc_pkg::ST_IDLE: begin
            if (req_beat) begin
               mode_in  = tbtc_pkg::mode_type'(req_tuser);
               state_in = tbtc_pkg::ST_DIV;
            end
         end
         tbtc_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = tbtc_pkg::ST_ROT;
            end
         end
         tbtc_pkg::ST_ROT: begin
            state_in = tbtc_pkg::ST_OP;
            if (!started_ff) begin
               started_in    = 1'b1;
               latched_in    = bucket;
               write_slot_in = '0;
            end else if (bucket > latched_ff) begin
               latched_in = bucket;
               if (gap >= tbtc_pkg::TS_W'(BUCKETS)) begin
                  // A gap of a whole ring or more wipes everything
                  ring_ctl.clr_all = 1'b1;
                  write_slot_in    = '0;
               end else begin
                  step_cnt_in = gap[IDX_W-1:0];
                  state_in    = tbtc_pkg::ST_STEP;
               end
            end
         end
         tbtc_pkg::ST_STEP: begin
            // Enter the next slot and clear it
            ring_ctl.clr_one = 1'b1;
            ring_wr_addr     = slot_step;
            write_slot_in    = slot_step;
            step_cnt_in      = step_cnt_ff - 1'b1;
            if (step_cnt_ff == IDX_W'(1)) begin
               state_in = tbtc_pkg::ST_OP;
            end
         end
         tbtc_pkg::ST_OP: begin
            if (mode_ff == tbtc_pkg::MODE_REC_RX || mode_ff == tbtc_pkg::MODE_REC_TX) begin
               ring_ctl.rd_en = 1'b1;
               ring_rd_addr   = write_slot_ff;
               state_in       = tbtc_pkg::ST_REC_WR;
            end else begin
               rd_ptr_in = slot_step;
               pos_in    = '0;
               state_in  = tbtc_pkg::ST_RD_A;
            end
         end
         tbtc_pkg::ST_REC_WR: begin
            // Saturating increment of the current bucket
            ring_ctl.wr_en = 1'b1;
            if (mode_ff == tbtc_pkg::MODE_REC_RX) begin
               if (ring_rd_data.rx != tbtc_pkg::COUNT_MAX) begin
                  ring_wr_data.rx = ring_rd_data.rx + 1'b1;
               end
            end else begin
               if (ring_rd_data.tx != tbtc_pkg::COUNT_MAX) begin
                  ring_wr_data.tx = ring_rd_data.tx + 1'b1;
               end
            end
            state_in = tbtc_pkg::ST_IDLE;
         end
         tbtc_pkg::ST_RD_A: begin
            ring_ctl.rd_en = 1'b1;
            rd_ptr_in      = next_slot(rd_ptr_ff);
            state_in       = (mode_ff == tbtc_pkg::MODE_READ_PAIR) ? tbtc_pkg::ST_RD_B
                                                                  : tbtc_pkg::ST_LOAD;
         end
         tbtc_pkg::ST_RD_B: begin
            pair_a_in      = ring_rd_data;
            ring_ctl.rd_en = 1'b1;
            rd_ptr_in      = next_slot(rd_ptr_ff);
            state_in       = tbtc_pkg::ST_LOAD;
         end
         tbtc_pkg::ST_LOAD: begin
            // Clamp into the result register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_hit;
               rsp_pos_in   = pos_ff;
               if (mode_ff == tbtc_pkg::MODE_READ_PAIR) begin
                  rsp_rx_in = (rx_sum > {1'b0, pair_clamp_ff}) ? pair_clamp_ff : rx_sum[CW-1:0];
                  rsp_tx_in = (tx_sum > {1'b0, pair_clamp_ff}) ? pair_clamp_ff : tx_sum[CW-1:0];
               end else begin
                  rsp_rx_in = (ring_rd_data.rx > fine_clamp_ff) ? fine_clamp_ff
                                                                : ring_rd_data.rx;
                  rsp_tx_in = (ring_rd_data.tx > fine_clamp_ff) ? fine_clamp_ff
                                                                : ring_rd_data.tx;
               end
               pos_in   = pos_ff + 1'b1;
               state_in = last_hit ? tbtc_pkg::ST_IDLE : tbtc_pkg::ST_RD_A;
            end
         end
         default: begin
            state_in = tbtc_pkg::ST_IDLE;
         end
      endcase
   end

   // Take configuration writes; unknown indexes drop
   always_comb begin
      fine_clamp_in = fine_clamp_ff;
      pair_clamp_in = pair_clamp_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tbtc_pkg::CSR_FINE_CLAMP: fine_clamp_in = csr_data;
            tbtc_pkg::CSR_PAIR_CLAMP: pair_clamp_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tbtc_pkg::ST_IDLE;
         started_ff    <= 1'b0;
         write_slot_ff <= '0;
         latched_ff    <= '0;
         fine_clamp_ff <= tbtc_pkg::FINE_CLAMP_RST;
         pair_clamp_ff <= tbtc_pkg::PAIR_CLAMP_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         write_slot_ff <= write_slot_in;
         latched_ff    <= latched_in;
         fine_clamp_ff <= fine_clamp_in;
         pair_clamp_ff <= pair_clamp_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      step_cnt_ff <= step_cnt_in;
      rd_ptr_ff   <= rd_ptr_in;
      pos_ff      <= pos_in;
      pair_a_ff   <= pair_a_in;
      rsp_last_ff <= rsp_last_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_rx_ff   <= rsp_rx_in;
      rsp_tx_ff   <= rsp_tx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_tx_ff, rsp_rx_ff, tbtc_pkg::POS_W'(rsp_pos_ff)};

`ifndef SYNTH
   // The write slot never leaves the ring
   assert property (@(posedge clock) disable iff (reset)
      write_slot_ff <= LAST_FINE)
      else $error("write slot outside the ring");

   // The divider finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == tbtc_pkg::ST_DIV)
      else $error("divider result outside the division phase");

   // An accepted beat closes the item channel until the item is done
   assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("item channel open while busy");
`endif

endmodule

FILE: dv/tb_top.sv
// Self-checking bench for the time-bucketed traffic counter: stream driver, monitor, ring model.
`timescale 1ns / 1ps

module tb_top;

   localparam int                        N_BKT        = tbtc_pkg::BUCKETS_DEF;
   localparam logic [tbtc_pkg::TS_W-1:0] LEN_MS       = tbtc_pkg::BUCKET_LENGTH_MS_DEF;
   localparam int                        LIMIT_CYCLES = 5000;
   localparam int                        HOLD_CYCLES  = 400;
   localparam int                        DRAIN_CYCLES = 200;
   localparam int                        PHASE_ITEMS  = 48;

   // Indexes beyond the two real registers; writes there must change nothing
   localparam logic [tbtc_pkg::CSR_A_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [tbtc_pkg::CSR_A_W-1:0] CSR_SPARE_B = 2'd3;

   typedef enum int {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_PATTERN,
      RDY_SPELLS
   } rdy_style_type;

   typedef struct {
      tbtc_pkg::mode_type         mode;
      logic [tbtc_pkg::TS_W-1:0]  stamp;
   } pend_item_type;

   typedef struct {
      logic [tbtc_pkg::POS_W-1:0] pos;
      logic [tbtc_pkg::CNT_W-1:0] rx;
      logic [tbtc_pkg::CNT_W-1:0] tx;
      logic                       last;
   } slot_beat_type;

   logic                          clock;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [tbtc_pkg::TS_W-1:0]     req_tdata  = '0;  // [31:0] now_ms
   logic [tbtc_pkg::MODE_W-1:0]   req_tuser  = '0;  // [1:0] mode
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [39:0]                   rsp_tdata;  // [5:0] position, [21:6] rx, [37:22] tx, [39:38] zero
   logic                          rsp_tlast;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [tbtc_pkg::CSR_A_W-1:0]  csr_index  = '0;
   logic [tbtc_pkg::CNT_W-1:0]    csr_data   = '0;

   // Ring model state and its copy of the registers
   logic [tbtc_pkg::CNT_W-1:0]    ring_rx [N_BKT];
   logic [tbtc_pkg::CNT_W-1:0]    ring_tx [N_BKT];
   int                            head_slot   = 0;
   logic [tbtc_pkg::TS_W-1:0]     latched_bkt = '0;
   bit                            ring_live   = 1'b0;
   logic [tbtc_pkg::CNT_W-1:0]    lim_fine    = tbtc_pkg::FINE_CLAMP_RST;
   logic [tbtc_pkg::CNT_W-1:0]    lim_pair    = tbtc_pkg::PAIR_CLAMP_RST;

   pend_item_type                 item_fifo [$];
   slot_beat_type                 due_beats [$];
   int                            err_count   = 0;
   int                            quiet_cycles = 0;

   // Sender and receiver pacing
   int                            gap_max     = 0;
   int                            gap_left    = 0;
   int                            burst_left  = 1;
   rdy_style_type                 rx_style    = RDY_ALWAYS;
   int                            hold_ask    = 0;
   int                            hold_seen   = 0;
   int                            hold_left   = 0;
   int                            spell_left  = 0;
   int                            pat_idx     = 0;
   logic [15:0]                   rdy_pattern = 16'b1110_0110_1011_0001;
   logic [tbtc_pkg::TS_W-1:0]     stamp_ms    = '0;

   time_bucketed_traffic_counter #(
      .BUCKETS          (tbtc_pkg::BUCKETS_DEF),
      .BUCKET_LENGTH_MS (tbtc_pkg::BUCKET_LENGTH_MS_DEF)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      for (int k = 0; k < N_BKT; k++) begin
         ring_rx[k] = '0;
         ring_tx[k] = '0;
      end
   end

   task automatic flag_error(input string what);
      $display("%0t mismatch: %s", $time, what);
      err_count++;
   endtask

   function automatic logic [tbtc_pkg::CNT_W-1:0] clip(input logic [tbtc_pkg::CNT_W:0] v,
                                                       input logic [tbtc_pkg::CNT_W-1:0] lim);
      return (v > {1'b0, lim}) ? lim : v[tbtc_pkg::CNT_W-1:0];
   endfunction

   // Advance the model ring to the bucket of this timestamp, clearing slots entered
   function automatic void step_ring(input logic [tbtc_pkg::TS_W-1:0] stamp);
      logic [tbtc_pkg::TS_W-1:0] bkt;
      logic [tbtc_pkg::TS_W-1:0] gap;
      bkt = stamp / LEN_MS;
      if (!ring_live) begin
         ring_live   = 1'b1;
         latched_bkt = bkt;
         head_slot   = 0;
         return;
      end
      if (bkt <= latched_bkt) return;
      gap = bkt - latched_bkt;
      if (gap >= N_BKT) begin
         for (int k = 0; k < N_BKT; k++) begin
            ring_rx[k] = '0;
            ring_tx[k] = '0;
         end
         head_slot = 0;
      end else begin
         for (int k = 0; k < int'(gap); k++) begin
            head_slot          = (head_slot + 1) % N_BKT;
            ring_rx[head_slot] = '0;
            ring_tx[head_slot] = '0;
         end
      end
      latched_bkt = bkt;
   endfunction

   // Update the model for one accepted item and queue the readout beats it causes
   task automatic account_item(input pend_item_type it);
      slot_beat_type want;
      int            oldest;
      int            a;
      int            b;
      step_ring(it.stamp);
      oldest = (head_slot + 1) % N_BKT;
      case (it.mode)
         tbtc_pkg::MODE_REC_RX: begin
            if (ring_rx[head_slot] != tbtc_pkg::COUNT_MAX) ring_rx[head_slot]++;
         end
         tbtc_pkg::MODE_REC_TX: begin
            if (ring_tx[head_slot] != tbtc_pkg::COUNT_MAX) ring_tx[head_slot]++;
         end
         tbtc_pkg::MODE_READ_FINE: begin
            for (int i = 0; i < N_BKT; i++) begin
               a         = (oldest + i) % N_BKT;
               want.pos  = tbtc_pkg::POS_W'(i);
               want.rx   = clip({1'b0, ring_rx[a]}, lim_fine);
               want.tx   = clip({1'b0, ring_tx[a]}, lim_fine);
               want.last = (i == N_BKT - 1);
               due_beats.push_back(want);
            end
         end
         default: begin
            for (int i = 0; i < N_BKT / 2; i++) begin
               a         = (oldest + 2 * i) % N_BKT;
               b         = (oldest + 2 * i + 1) % N_BKT;
               want.pos  = tbtc_pkg::POS_W'(i);
               want.rx   = clip({1'b0, ring_rx[a]} + {1'b0, ring_rx[b]}, lim_pair);
               want.tx   = clip({1'b0, ring_tx[a]} + {1'b0, ring_tx[b]}, lim_pair);
               want.last = (i == N_BKT / 2 - 1);
               due_beats.push_back(want);
            end
         end
      endcase
   endtask

   // Compare one accepted result beat with the oldest one due
   task automatic check_beat();
      slot_beat_type want;
      if (due_beats.size() == 0) begin
         flag_error($sformatf("beat at position %0d with nothing due", rsp_tdata[5:0]));
         return;
      end
      want = due_beats.pop_front();
      if (rsp_tdata[5:0] != want.pos)
         flag_error($sformatf("position %0d, want %0d", rsp_tdata[5:0], want.pos));
      if (rsp_tdata[21:6] != want.rx)
         flag_error($sformatf("pos %0d rx %0d, want %0d", want.pos, rsp_tdata[21:6], want.rx));
      if (rsp_tdata[37:22] != want.tx)
         flag_error($sformatf("pos %0d tx %0d, want %0d", want.pos, rsp_tdata[37:22], want.tx));
      if (rsp_tdata[39:38] != 2'b00)
         flag_error($sformatf("pos %0d padding bits %b", want.pos, rsp_tdata[39:38]));
      if (rsp_tlast != want.last)
         flag_error($sformatf("pos %0d tlast %b, want %b", want.pos, rsp_tlast, want.last));
   endtask

   // Driver: offer queued items in bursts, holding each beat until taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            account_item(item_fifo.pop_front());
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 10);
               gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (item_fifo.size() != 0) begin
               req_tvalid <= 1'b1;
               req_tuser  <= item_fifo[0].mode;
               req_tdata  <= item_fifo[0].stamp;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check taken beats, then pick the next ready level
   always @(posedge clock) begin
      logic ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_beat();
         if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
         end
         pat_idx = (pat_idx + 1) % 16;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (rx_style)
               RDY_ALWAYS:  ready_next = 1'b1;
               RDY_COIN:    ready_next = ($urandom_range(0, 3) != 0);
               RDY_PATTERN: ready_next = rdy_pattern[pat_idx];
               default: begin
                  if (spell_left > 0) begin
                     spell_left--;
                     ready_next = 1'b0;
                  end else if ($urandom_range(0, 15) == 0) begin
                     spell_left = $urandom_range(2, 12);
                     ready_next = 1'b0;
                  end else begin
                     ready_next = 1'b1;
                  end
               end
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   // Watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(input logic [tbtc_pkg::CSR_A_W-1:0] idx,
                            input logic [tbtc_pkg::CNT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == tbtc_pkg::CSR_FINE_CLAMP) lim_fine = val;
      else if (idx == tbtc_pkg::CSR_PAIR_CLAMP) lim_pair = val;
   endtask

   task automatic offer(input tbtc_pkg::mode_type mode, input logic [tbtc_pkg::TS_W-1:0] stamp);
      pend_item_type it;
      it.mode  = mode;
      it.stamp = stamp;
      item_fifo.push_back(it);
   endtask

   // Wait for every item taken and every beat in, then let the block go quiet
   task automatic settle();
      while (item_fifo.size() != 0 || due_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Corner timestamps: first item, equal and backward time, gaps just under and at a ring
   task automatic queue_directed();
      offer(tbtc_pkg::MODE_READ_FINE, 32'd0);
      offer(tbtc_pkg::MODE_REC_RX,    32'd59999);
      offer(tbtc_pkg::MODE_REC_TX,    32'd60000);
      offer(tbtc_pkg::MODE_REC_TX,    32'd60001);
      offer(tbtc_pkg::MODE_REC_RX,    32'd30000);
      offer(tbtc_pkg::MODE_READ_FINE, 32'd60000);
      offer(tbtc_pkg::MODE_READ_PAIR, 32'd60000);
      offer(tbtc_pkg::MODE_REC_RX,    32'd3780005);
      offer(tbtc_pkg::MODE_REC_TX,    32'd3840000);
      offer(tbtc_pkg::MODE_READ_FINE, 32'd3840000);
      offer(tbtc_pkg::MODE_READ_PAIR, 32'd3840000);
      offer(tbtc_pkg::MODE_REC_RX,    32'd7680000);
      offer(tbtc_pkg::MODE_REC_TX,    32'd7680000);
      offer(tbtc_pkg::MODE_READ_PAIR, 32'd11460000);
      offer(tbtc_pkg::MODE_REC_RX,    32'hFFFF_FFFF);
      offer(tbtc_pkg::MODE_REC_TX,    32'hFFFF_FFFF);
      offer(tbtc_pkg::MODE_READ_FINE, 32'hFFFF_FFFF);
      offer(tbtc_pkg::MODE_REC_RX,    32'd0);
      offer(tbtc_pkg::MODE_READ_PAIR, 32'd0);
      stamp_ms = 32'd0;
   endtask

   // Mostly records packed into few buckets, with jumps of every size now and then
   task automatic queue_random(input int count, input bit lead_read);
      int                 r;
      tbtc_pkg::mode_type mode;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 55)      stamp_ms += $urandom_range(0, 20000);
         else if (r < 75) stamp_ms += LEN_MS * $urandom_range(1, 3);
         else if (r < 83) stamp_ms -= $urandom_range(0, 200000);
         else if (r < 89) stamp_ms += LEN_MS * $urandom_range(4, 63);
         else if (r < 94) stamp_ms += LEN_MS * $urandom_range(64, 5000);
         else             stamp_ms = $urandom;
         r = $urandom_range(0, 99);
         if (lead_read && n == 0) mode = tbtc_pkg::MODE_READ_FINE;
         else if (r < 38)         mode = tbtc_pkg::MODE_REC_RX;
         else if (r < 76)         mode = tbtc_pkg::MODE_REC_TX;
         else if (r < 88)         mode = tbtc_pkg::MODE_READ_FINE;
         else                     mode = tbtc_pkg::MODE_READ_PAIR;
         offer(mode, stamp_ms);
      end
   endtask

   initial begin
      logic [tbtc_pkg::CNT_W-1:0] fine_set [6];
      logic [tbtc_pkg::CNT_W-1:0] pair_set [6];
      int                         gap_set  [6];
      fine_set = '{16'hFFFF, 16'd0, 16'd1, 16'd3, 16'd0, 16'hFFFF};
      pair_set = '{16'hFFFF, 16'd0, 16'd2, 16'd1, 16'd0, 16'd0};
      gap_set  = '{4, 0, 8, 2, 6, 3};
      fine_set[4] = tbtc_pkg::CNT_W'($urandom_range(0, 65535));
      pair_set[4] = tbtc_pkg::CNT_W'($urandom_range(0, 65535));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset register values first, then a run of register settings
      rx_style = RDY_COIN;
      gap_max  = 3;
      queue_directed();
      settle();

      for (int p = 0; p < 6; p++) begin
         write_reg(tbtc_pkg::CSR_FINE_CLAMP, fine_set[p]);
         write_reg(tbtc_pkg::CSR_PAIR_CLAMP, pair_set[p]);
         if (p == 4) begin
            write_reg(CSR_SPARE_A, tbtc_pkg::CNT_W'($urandom_range(0, 65535)));
            write_reg(CSR_SPARE_B, tbtc_pkg::CNT_W'($urandom_range(0, 65535)));
         end
         rx_style = rdy_style_type'(p % 4);
         gap_max  = gap_set[p];
         // Long receiver hold-off while the sender keeps offering
         if (p == 0) hold_ask++;
         queue_random(PHASE_ITEMS, p == 0);
         settle();
      end

      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
